/* design/ucep_pkg.sv */
// Shared types, codes and helpers for the endpoint-zero control sequencer.
`default_nettype none

package ucep_pkg;

  localparam logic [6:0] PACKET_SIZE = 7'd64;

  typedef enum logic [2:0] {
    OP_SEND      = 3'd0,
    OP_RECEIVE   = 3'd1,
    OP_ACK       = 3'd2,
    OP_ERROR     = 3'd3,
    OP_IN_DONE   = 3'd4,
    OP_OUT_DONE  = 3'd5,
    OP_ENUM_DONE = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_WAIT_SETUP = 3'd0,
    ST_IN_DATA    = 3'd1,
    ST_OUT_DATA   = 3'd2,
    ST_LAST_IN    = 3'd3,
    ST_STATUS_IN  = 3'd4,
    ST_STATUS_OUT = 3'd5
  } stage_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] data_length;
    logic [15:0] host_length;
    logic [6:0]  received_count;
  } cmd_t;

  typedef struct packed {
    logic        arm_setup;
    logic        arm_in;
    logic        arm_out;
    logic        stall_both;
    logic [6:0]  packet_length;
    logic [15:0] packet_offset;
    logic [2:0]  new_stage;
  } result_t;

  function automatic logic [6:0] min_pkt(input logic [15:0] n);
    return (n < {9'd0, PACKET_SIZE}) ? n[6:0] : PACKET_SIZE;
  endfunction

endpackage

`default_nettype wire

/* design/ucep_core.sv */
// Stage, length and offset registers with the per-item next-state and action logic.
`default_nettype none

module ucep_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire ucep_pkg::cmd_t   item,
  output ucep_pkg::result_t     result
);

  ucep_pkg::stage_t stage, stage_next;
  logic [15:0]      remaining, remaining_next;
  logic [15:0]      offset, offset_next;
  logic             zlp_pending, zlp_pending_next;

  logic [15:0] clip_len;
  logic [6:0]  first_len;
  logic [6:0]  rem_len;
  logic [15:0] rx_count;
  logic [15:0] rx_left;
  logic [15:0] rx_offset;
  logic        in_stage;

  assign clip_len  = (item.data_length > item.host_length) ? item.host_length : item.data_length;
  assign first_len = ucep_pkg::min_pkt(clip_len);
  assign rem_len   = ucep_pkg::min_pkt(remaining);
  assign rx_count  = {9'd0, item.received_count};
  assign rx_left   = (rx_count > remaining) ? 16'd0 : remaining - rx_count;
  assign rx_offset = offset + rx_count;
  assign in_stage  = (stage == ucep_pkg::ST_IN_DATA) || (stage == ucep_pkg::ST_LAST_IN);

  always_comb begin
    stage_next       = stage;
    remaining_next   = remaining;
    offset_next      = offset;
    zlp_pending_next = zlp_pending;
    case (item.opcode)
      ucep_pkg::OP_SEND: begin
        zlp_pending_next = (clip_len != 16'd0) &&
                           ((clip_len & ({9'd0, ucep_pkg::PACKET_SIZE} - 16'd1)) == 16'd0);
        stage_next       = (clip_len < {9'd0, ucep_pkg::PACKET_SIZE}) ?
                           ucep_pkg::ST_LAST_IN : ucep_pkg::ST_IN_DATA;
        remaining_next   = clip_len - {9'd0, first_len};
        offset_next      = {9'd0, first_len};
      end
      ucep_pkg::OP_RECEIVE: begin
        remaining_next = item.data_length;
        offset_next    = 16'd0;
        stage_next     = ucep_pkg::ST_OUT_DATA;
      end
      ucep_pkg::OP_ACK: begin
        stage_next = ucep_pkg::ST_STATUS_IN;
      end
      ucep_pkg::OP_ERROR: begin
        stage_next = ucep_pkg::ST_WAIT_SETUP;
      end
      ucep_pkg::OP_IN_DONE: begin
        if (in_stage) begin
          if ((remaining == 16'd0) && (stage == ucep_pkg::ST_LAST_IN)) begin
            if (zlp_pending) begin
              zlp_pending_next = 1'b0;
            end else begin
              stage_next = ucep_pkg::ST_STATUS_OUT;
            end
          end else begin
            stage_next     = (remaining <= {9'd0, ucep_pkg::PACKET_SIZE}) ?
                             ucep_pkg::ST_LAST_IN : ucep_pkg::ST_IN_DATA;
            remaining_next = remaining - {9'd0, rem_len};
            offset_next    = offset + {9'd0, rem_len};
          end
        end else begin
          stage_next = ucep_pkg::ST_WAIT_SETUP;
        end
      end
      ucep_pkg::OP_OUT_DONE: begin
        case (stage)
          ucep_pkg::ST_WAIT_SETUP: begin
            stage_next = ucep_pkg::ST_WAIT_SETUP;
          end
          ucep_pkg::ST_OUT_DATA: begin
            remaining_next = rx_left;
            offset_next    = rx_offset;
            stage_next     = (rx_left == 16'd0) ? ucep_pkg::ST_STATUS_IN : ucep_pkg::ST_OUT_DATA;
          end
          default: begin
            stage_next = ucep_pkg::ST_WAIT_SETUP;
          end
        endcase
      end
      ucep_pkg::OP_ENUM_DONE: begin
        stage_next = ucep_pkg::ST_WAIT_SETUP;
      end
      default: begin
        stage_next = stage;
      end
    endcase
  end

  always_comb begin
    result               = '0;
    result.new_stage     = stage_next;
    case (item.opcode)
      ucep_pkg::OP_SEND: begin
        result.arm_in        = 1'b1;
        result.packet_length = first_len;
      end
      ucep_pkg::OP_RECEIVE: begin
        result.arm_out       = 1'b1;
        result.packet_length = ucep_pkg::min_pkt(item.data_length);
      end
      ucep_pkg::OP_ACK: begin
        result.arm_setup = 1'b1;
        result.arm_in    = 1'b1;
      end
      ucep_pkg::OP_ERROR: begin
        result.arm_setup  = 1'b1;
        result.stall_both = 1'b1;
      end
      ucep_pkg::OP_IN_DONE: begin
        if (in_stage) begin
          if ((remaining == 16'd0) && (stage == ucep_pkg::ST_LAST_IN)) begin
            if (zlp_pending) begin
              result.arm_setup = 1'b1;
              result.arm_in    = 1'b1;
            end else begin
              result.arm_out = 1'b1;
            end
          end else begin
            result.arm_setup     = 1'b1;
            result.arm_in        = 1'b1;
            result.packet_length = rem_len;
            result.packet_offset = offset;
          end
        end else if (stage == ucep_pkg::ST_STATUS_IN) begin
          result.arm_setup = 1'b1;
        end else begin
          result.arm_setup  = 1'b1;
          result.stall_both = 1'b1;
        end
      end
      ucep_pkg::OP_OUT_DONE: begin
        case (stage)
          ucep_pkg::ST_WAIT_SETUP, ucep_pkg::ST_STATUS_IN: begin
            result.arm_setup = 1'b0;
          end
          ucep_pkg::ST_OUT_DATA: begin
            if (rx_left == 16'd0) begin
              result.arm_setup = 1'b1;
              result.arm_in    = 1'b1;
            end else begin
              result.arm_out       = 1'b1;
              result.packet_length = ucep_pkg::min_pkt(rx_left);
              result.packet_offset = rx_offset;
            end
          end
          ucep_pkg::ST_STATUS_OUT: begin
            result.arm_setup = 1'b1;
          end
          default: begin
            result.arm_setup  = 1'b1;
            result.stall_both = 1'b1;
          end
        endcase
      end
      ucep_pkg::OP_ENUM_DONE: begin
        result.arm_setup = 1'b1;
      end
      default: begin
        result.arm_setup = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= ucep_pkg::ST_WAIT_SETUP;
      remaining   <= 16'd0;
      offset      <= 16'd0;
      zlp_pending <= 1'b0;
    end else if (fire) begin
      stage       <= stage_next;
      remaining   <= remaining_next;
      offset      <= offset_next;
      zlp_pending <= zlp_pending_next;
    end
  end

endmodule

`default_nettype wire

/* design/ucep_out_reg.sv */
// Result register with valid/stall handshake toward the consumer.
`default_nettype none

module ucep_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire ucep_pkg::result_t  data,
  input  wire logic               result_stall,
  output logic                    result_valid,
  output ucep_pkg::result_t       result
);

  logic result_valid_next;

  assign result_valid_next = load | (result_valid & result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= data;
    end
  end

endmodule

`default_nettype wire

/* design/usb_control_endpoint_sequencer.sv */
// Top level of the endpoint-zero control transfer sequencer.
//
//   channel  | direction | payload            | handshake
//   ---------+-----------+--------------------+---------------------------
//   cmd      | in        | ucep_pkg::cmd_t    | cmd_valid / cmd_stall
//   result   | out       | ucep_pkg::result_t | result_valid / result_stall
//
// An item passes the command register, then the result register; one item
// per cycle is sustained unless the result stalls, set by the single-pass
// stage/length/offset update. Reset clears stage, lengths and both valids.
// A stalled result holds the result register; a second item may wait in the
// command register, and cmd_stall rises only when both registers are full.
`default_nettype none

module usb_control_endpoint_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ucep_pkg::cmd_t     cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  output ucep_pkg::result_t       result,
  output logic                    result_valid,
  input  wire logic               result_stall
);

  ucep_pkg::cmd_t    cmd_q;
  logic              cmd_q_valid, cmd_q_valid_next;
  logic              advance;
  logic              take;
  ucep_pkg::result_t core_result;

  assign advance          = cmd_q_valid & (~result_valid | ~result_stall);
  assign cmd_stall        = cmd_q_valid & ~advance;
  assign take             = cmd_valid & ~cmd_stall;
  assign cmd_q_valid_next = take | (cmd_q_valid & ~advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else begin
      cmd_q_valid <= cmd_q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q <= cmd;
    end
  end

  ucep_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (cmd_q),
    .result (core_result)
  );

  ucep_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .data         (core_result),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

/* design/ucep_checker.sv */
// Port-level checks for the endpoint-zero control sequencer, bound to the top level.
`default_nettype none

module ucep_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire ucep_pkg::cmd_t    cmd,
  input wire logic              cmd_valid,
  input wire logic              cmd_stall,
  input wire ucep_pkg::result_t result,
  input wire logic              result_valid,
  input wire logic              result_stall
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_stall_returns: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stall_both |->
      result.arm_setup && result.new_stage == ucep_pkg::ST_WAIT_SETUP)
    else $error("stall without setup re-arm or return to wait setup");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.packet_length <= ucep_pkg::PACKET_SIZE)
    else $error("packet length beyond packet size");

  a_reply_stage: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.arm_in && !result.arm_setup |->
      result.new_stage == ucep_pkg::ST_IN_DATA || result.new_stage == ucep_pkg::ST_LAST_IN)
    else $error("reply armed outside an IN data stage");

endmodule

bind usb_control_endpoint_sequencer ucep_checker u_ucep_checker (.*);

`default_nettype wire
